@@ rtl/core/sngs_pkg.sv @@
package sngs_pkg;

    // result kinds carried on the master tuser
    typedef enum logic [2:0]
    {
        ST_PRESENT  = 3'd0,
        ST_INSERTED = 3'd1,
        ST_FULL     = 3'd2,
        ST_READ     = 3'd3,
        ST_RANGE    = 3'd4
    } status_t;

    // field widths fixed by the stream format
    localparam int unsigned CFG_BITS   = 5;
    localparam int unsigned INDEX_BITS = 10;
    localparam int unsigned ELEM_BITS  = 5;
    localparam int unsigned POS_BITS   = 10;
    localparam int unsigned COUNT_BITS = 11;

endpackage

@@ rtl/core/sngs_ram.sv @@
module sngs_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 1024,
    localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/core/sorted_ngram_set_insert.sv @@
// Sorted n-gram key set with binary-search insert.
// Slave stream: tuser = operation (0 key symbol, 1 read), tdata = symbol,
// entry_index, element_position. Each key is gram_length symbols; the last
// symbol starts a binary search of the sorted table memory, then either a
// "present" result, an insert (later entries move up one place) or "full".
// A read transaction returns one symbol of a stored entry.
// Master stream: tuser = status, tdata = position, read_value, entry_count.
// Symbol transactions that do not finish a key give no result.
// All transactions work through the one table memory, which has one write
// port and one registered read port: a read fetches one stored symbol unless
// out of range; a key lookup makes probes <= log2(entry_count) + 1, each
// comparing symbols until one differs; an insert then moves the later
// entries up word by word and writes the gram_length new symbols.
// A new transaction is taken only when the sequencer is idle and no
// configuration write is under way; a finished result waits in the output
// register, so a stalled receiver blocks the block only once the next
// result is ready.
// Reset empties the table, clears key assembly and sets gram_length to 4;
// no memory clearing pass is needed. Writing gram_length (cfg_we) also
// empties the table; values 0 and above MAX_GRAM are clamped.
module sorted_ngram_set_insert #(
    parameter int unsigned TABLE_DEPTH = 1024,
    parameter int unsigned MAX_GRAM    = 20,
    parameter int unsigned SYMBOL_BITS = 16,
    localparam int unsigned IN_W  = ((SYMBOL_BITS + 15 + 7) / 8) * 8,
    localparam int unsigned OUT_W = ((SYMBOL_BITS + 21 + 7) / 8) * 8
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [sngs_pkg::CFG_BITS-1:0] cfg_wdata,  // gram_length
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_W-1:0]       s_tdata,   // symbol, entry_index, element_position
    input  logic                  s_tuser,   // operation
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_W-1:0]      m_tdata,   // position, read_value, entry_count
    output logic [2:0]            m_tuser    // status
);

    import sngs_pkg::*;

    localparam int unsigned SB = SYMBOL_BITS;
    localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
    localparam int unsigned GW = $clog2(MAX_GRAM + 1);
    localparam int unsigned BW = (MAX_GRAM > 1) ? $clog2(MAX_GRAM) : 1;
    localparam int unsigned WORDS = TABLE_DEPTH * MAX_GRAM;
    localparam int unsigned AW = (WORDS > 1) ? $clog2(WORDS) : 1;

    typedef enum logic [3:0]
    {
        S_IDLE,
        S_RD_BASE,
        S_RD_ISSUE,
        S_RD_DATA,
        S_SEARCH,
        S_CMP_RD,
        S_CMP_CHK,
        S_LOBASE,
        S_SHSTART,
        S_SH_RD,
        S_SH_WR,
        S_WRITE,
        S_OUT
    } state_t;

    state_t              state_reg;
    logic [GW-1:0]       gram_reg;
    logic [GW-1:0]       sym_cnt_reg;
    logic [CW-1:0]       count_reg;
    logic [CW-1:0]       lo_reg;
    logic [CW-1:0]       hi_reg;
    logic [CW-1:0]       mid_reg;
    logic [GW-1:0]       elem_reg;
    logic [AW-1:0]       base_reg;
    logic [AW-1:0]       src_reg;
    logic [INDEX_BITS-1:0] idx_reg;
    logic [ELEM_BITS-1:0]  epos_reg;
    status_t             res_status_reg;
    logic [POS_BITS-1:0] res_pos_reg;
    logic [SB-1:0]       res_val_reg;
    logic                m_tvalid_reg;
    logic [OUT_W-1:0]    m_tdata_reg;
    logic [2:0]          m_tuser_reg;

    logic signed [SB-1:0] key_buf [MAX_GRAM];

    logic                 in_accept;
    logic [SB-1:0]        in_symbol;
    logic [INDEX_BITS-1:0] in_index;
    logic [ELEM_BITS-1:0]  in_elem;
    logic [CW-1:0]        mid;
    logic [CW-1:0]        mul_a;
    logic [AW-1:0]        product;
    logic                 ram_we;
    logic [AW-1:0]        ram_waddr;
    logic [SB-1:0]        ram_wdata;
    logic [AW-1:0]        ram_raddr;
    logic [SB-1:0]        ram_rdata;
    logic signed [SB-1:0] buf_sym;
    logic signed [SB-1:0] mem_sym;
    logic [GW-1:0]        cfg_gram;
    logic                 out_free;
    logic                 rd_ok;

    // input field split
    assign in_symbol = s_tdata[SB-1:0];
    assign in_index  = s_tdata[SB+INDEX_BITS-1:SB];
    assign in_elem   = s_tdata[SB+INDEX_BITS+ELEM_BITS-1:SB+INDEX_BITS];

    assign s_tready  = (state_reg == S_IDLE) && !cfg_we;
    assign in_accept = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // clamped gram length from the configuration port
    always_comb
    begin
        if (cfg_wdata == '0)
        begin
            cfg_gram = GW'(1);
        end
        else if (32'(cfg_wdata) > MAX_GRAM)
        begin
            cfg_gram = GW'(MAX_GRAM);
        end
        else
        begin
            cfg_gram = GW'(cfg_wdata);
        end
    end

    // midpoint and the shared entry-to-address multiplier
    assign mid = lo_reg + ((hi_reg - lo_reg) >> 1);

    always_comb
    begin
        case (state_reg)
            S_SEARCH:  mul_a = mid;
            S_LOBASE:  mul_a = lo_reg;
            S_SHSTART: mul_a = count_reg;
            default:   mul_a = CW'(idx_reg);
        endcase
    end

    assign product = AW'(AW'(mul_a) * AW'(MAX_GRAM));

    // range check for a read transaction
    assign rd_ok = (32'(idx_reg) < 32'(count_reg)) && (32'(epos_reg) < 32'(gram_reg));

    // compare operands
    assign buf_sym = key_buf[elem_reg[BW-1:0]];
    assign mem_sym = $signed(ram_rdata);

    // table memory ports
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_wdata = '0;
        ram_raddr = '0;
        case (state_reg)
            S_RD_ISSUE: ram_raddr = AW'(base_reg + AW'(epos_reg));
            S_CMP_RD:   ram_raddr = AW'(base_reg + AW'(elem_reg));
            S_SH_RD:    ram_raddr = src_reg;
            S_SH_WR:
            begin
                ram_we    = 1'b1;
                ram_waddr = AW'(src_reg + AW'(MAX_GRAM));
                ram_wdata = ram_rdata;
            end
            S_WRITE:
            begin
                ram_we    = 1'b1;
                ram_waddr = AW'(base_reg + AW'(elem_reg));
                ram_wdata = buf_sym;
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    sngs_ram #(
        .WIDTH (SB),
        .DEPTH (WORDS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // key assembly buffer
    always_ff @(posedge clk)
    begin
        if (in_accept && !s_tuser)
        begin
            key_buf[sym_cnt_reg[BW-1:0]] <= $signed(in_symbol);
        end
    end

    // sequencer and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            gram_reg       <= GW'(4);
            sym_cnt_reg    <= '0;
            count_reg      <= '0;
            lo_reg         <= '0;
            hi_reg         <= '0;
            mid_reg        <= '0;
            elem_reg       <= '0;
            base_reg       <= '0;
            src_reg        <= '0;
            idx_reg        <= '0;
            epos_reg       <= '0;
            res_status_reg <= ST_PRESENT;
            res_pos_reg    <= '0;
            res_val_reg    <= '0;
            m_tvalid_reg   <= 1'b0;
            m_tdata_reg    <= '0;
            m_tuser_reg    <= '0;
        end
        else
        begin
            // output valid: set when a result is loaded, cleared when taken
            if (state_reg == S_OUT && out_free)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end

            if (cfg_we)
            begin
                gram_reg    <= cfg_gram;
                count_reg   <= '0;
                sym_cnt_reg <= '0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (in_accept)
                    begin
                        idx_reg  <= in_index;
                        epos_reg <= in_elem;
                        if (s_tuser)
                        begin
                            state_reg <= S_RD_BASE;
                        end
                        else if (sym_cnt_reg + GW'(1) >= gram_reg)
                        begin
                            sym_cnt_reg <= '0;
                            lo_reg      <= '0;
                            hi_reg      <= count_reg;
                            state_reg   <= S_SEARCH;
                        end
                        else
                        begin
                            sym_cnt_reg <= sym_cnt_reg + GW'(1);
                        end
                    end
                end

                // read transaction
                S_RD_BASE:
                begin
                    base_reg    <= product;
                    res_pos_reg <= '0;
                    res_val_reg <= '0;
                    if (rd_ok)
                    begin
                        state_reg <= S_RD_ISSUE;
                    end
                    else
                    begin
                        res_status_reg <= ST_RANGE;
                        state_reg      <= S_OUT;
                    end
                end

                S_RD_ISSUE:
                begin
                    state_reg <= S_RD_DATA;
                end

                S_RD_DATA:
                begin
                    res_status_reg <= ST_READ;
                    res_val_reg    <= ram_rdata;
                    state_reg      <= S_OUT;
                end

                // binary search step
                S_SEARCH:
                begin
                    res_val_reg <= '0;
                    if (lo_reg < hi_reg)
                    begin
                        mid_reg   <= mid;
                        base_reg  <= product;
                        elem_reg  <= '0;
                        state_reg <= S_CMP_RD;
                    end
                    else if (32'(count_reg) >= TABLE_DEPTH)
                    begin
                        res_status_reg <= ST_FULL;
                        res_pos_reg    <= '0;
                        state_reg      <= S_OUT;
                    end
                    else
                    begin
                        state_reg <= S_LOBASE;
                    end
                end

                S_CMP_RD:
                begin
                    state_reg <= S_CMP_CHK;
                end

                // compare one key symbol with the probed entry's symbol just read
                S_CMP_CHK:
                begin
                    if (buf_sym < mem_sym)
                    begin
                        hi_reg    <= mid_reg;
                        state_reg <= S_SEARCH;
                    end
                    else if (buf_sym > mem_sym)
                    begin
                        lo_reg    <= mid_reg + CW'(1);
                        state_reg <= S_SEARCH;
                    end
                    else if (elem_reg + GW'(1) >= gram_reg)
                    begin
                        res_status_reg <= ST_PRESENT;
                        res_pos_reg    <= POS_BITS'(mid_reg);
                        state_reg      <= S_OUT;
                    end
                    else
                    begin
                        elem_reg  <= elem_reg + GW'(1);
                        state_reg <= S_CMP_RD;
                    end
                end

                // insert point found
                S_LOBASE:
                begin
                    base_reg <= product;
                    elem_reg <= '0;
                    if (lo_reg == count_reg)
                    begin
                        state_reg <= S_WRITE;
                    end
                    else
                    begin
                        state_reg <= S_SHSTART;
                    end
                end

                S_SHSTART:
                begin
                    src_reg   <= AW'(product - AW'(1));
                    state_reg <= S_SH_RD;
                end

                // move later entries up one place, top word first
                S_SH_RD:
                begin
                    state_reg <= S_SH_WR;
                end

                S_SH_WR:
                begin
                    if (src_reg == base_reg)
                    begin
                        state_reg <= S_WRITE;
                    end
                    else
                    begin
                        src_reg   <= src_reg - AW'(1);
                        state_reg <= S_SH_RD;
                    end
                end

                // write the new key into the gap
                S_WRITE:
                begin
                    if (elem_reg + GW'(1) >= gram_reg)
                    begin
                        count_reg      <= count_reg + CW'(1);
                        res_status_reg <= ST_INSERTED;
                        res_pos_reg    <= POS_BITS'(lo_reg);
                        state_reg      <= S_OUT;
                    end
                    else
                    begin
                        elem_reg <= elem_reg + GW'(1);
                    end
                end

                // hand the result to the output register
                S_OUT:
                begin
                    if (out_free)
                    begin
                        m_tuser_reg  <= res_status_reg;
                        m_tdata_reg  <= OUT_W'({COUNT_BITS'(count_reg), res_val_reg,
                                                res_pos_reg});
                        state_reg    <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTH
    // the table never holds more keys than its depth
    assert property (@(posedge clk) disable iff (!rst_n)
        32'(count_reg) <= TABLE_DEPTH)
    else $error("stored key count beyond table depth");

    // key assembly never runs past the gram length
    assert property (@(posedge clk) disable iff (!rst_n)
        sym_cnt_reg < gram_reg)
    else $error("symbol counter beyond gram length");

    // a finished result reaches the output register once it is free
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT && out_free) |=> (m_tvalid && state_reg == S_IDLE))
    else $error("result not presented");

    // an insert grows the table by exactly one key
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WRITE && elem_reg + GW'(1) >= gram_reg && !cfg_we)
        |=> (count_reg == $past(count_reg) + CW'(1)))
    else $error("insert did not grow the table");
`endif

endmodule
